FILE: hdl/bdca_pkg.sv
`timescale 1ns / 1ps

package bdca_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [1:0] CFG_LONG_PRESS = 2'd1;
  localparam logic [1:0] CFG_REPEAT     = 2'd2;
  localparam logic [1:0] CFG_STEP       = 2'd3;

  localparam int unsigned TIMER_W  = 16;
  localparam int unsigned STABLE_W = 17;
  localparam int unsigned STEP_W   = 8;

  typedef logic [TIMER_W-1:0]  timer_t;
  typedef logic [STABLE_W-1:0] stable_t;
  typedef logic [STEP_W-1:0]   step_t;

  localparam timer_t DEBOUNCE_RST   = 16'd50;
  localparam timer_t LONG_PRESS_RST = 16'd1000;
  localparam timer_t REPEAT_RST     = 16'd500;
  localparam step_t  STEP_RST       = 8'd5;

  localparam timer_t  TIMER_MAX  = '1;
  localparam stable_t STABLE_MAX = '1;

endpackage

FILE: hdl/button_debounce_click_autorepeat.sv
`timescale 1ns / 1ps

// Channel | Direction | Handshake                  | Payload
// input   | in        | in_valid_i / in_ready_o    | level_i, take_click_i, take_repeat_i
// output  | out       | out_valid_o / out_ready_i  | click_o, repeat_amount_o, held_o
// config  | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One item per cycle: an accepted tick updates the debounce and press state
// at that edge, and its result is loaded into the output register at the same edge.
// The single output register sets the rate; a new item is taken whenever that
// register is empty or is being drained in the same cycle.
// A stalled output holds in_ready_o low and freezes the debounce and press state.
// Reset (rst_ni low, asynchronous) clears all timers and flags and loads the
// register defaults: debounce 50, long press 1000, repeat 500, step 5.
// Configuration writes are always taken (cfg_ready_o is tied high).

module button_debounce_click_autorepeat (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tick items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        level_i,
  input  logic        take_click_i,
  input  logic        take_repeat_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        click_o,
  output logic [7:0]  repeat_amount_o,
  output logic        held_o,
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  // Configuration registers
  bdca_pkg::timer_t debounce_q, long_press_q, repeat_ticks_q;
  bdca_pkg::step_t  step_q;

  // Tick state
  logic              prev_level_q, prev_level_d;
  bdca_pkg::stable_t stable_q, stable_d;
  logic              pressed_q, pressed_d;
  bdca_pkg::timer_t  press_q, press_d;
  bdca_pkg::timer_t  rep_cnt_q, rep_cnt_d;
  logic              click_q, click_d;
  logic              rep_pend_q, rep_pend_d;

  // Result register
  logic              out_valid_q;
  logic              out_click_q, out_click_d;
  bdca_pkg::step_t   out_amount_q, out_amount_d;
  logic              out_held_q, out_held_d;

  logic              in_fire;
  logic              stable_ok;

  assign cfg_ready_o = 1'b1;
  // Take a new item while the result slot is empty or draining.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q     <= bdca_pkg::DEBOUNCE_RST;
      long_press_q   <= bdca_pkg::LONG_PRESS_RST;
      repeat_ticks_q <= bdca_pkg::REPEAT_RST;
      step_q         <= bdca_pkg::STEP_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bdca_pkg::CFG_DEBOUNCE:   debounce_q     <= cfg_data_i;
        bdca_pkg::CFG_LONG_PRESS: long_press_q   <= cfg_data_i;
        bdca_pkg::CFG_REPEAT:     repeat_ticks_q <= cfg_data_i;
        bdca_pkg::CFG_STEP:       step_q         <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // One tick of the debouncer, in the same order as the behavior is defined:
  // advance timers, track stability, then act on press, repeat and release.
  always_comb begin
    press_d      = press_q;
    rep_cnt_d    = rep_cnt_q;
    pressed_d    = pressed_q;
    click_d      = click_q;
    rep_pend_d   = rep_pend_q;
    prev_level_d = level_i;

    // Press timers run on every tick while pressed, stable or bouncing.
    if (pressed_q) begin
      if (press_q != bdca_pkg::TIMER_MAX)   press_d   = press_q + 1'b1;
      if (rep_cnt_q != bdca_pkg::TIMER_MAX) rep_cnt_d = rep_cnt_q + 1'b1;
    end

    // Any level change restarts the stable count.
    if (level_i != prev_level_q) begin
      stable_d = '0;
    end else if (stable_q != bdca_pkg::STABLE_MAX) begin
      stable_d = stable_q + 1'b1;
    end else begin
      stable_d = stable_q;
    end

    stable_ok = stable_d > {1'b0, debounce_q};

    if (stable_ok) begin
      // Debounced press: restart timers, drop anything pending.
      if (level_i && !pressed_d) begin
        pressed_d  = 1'b1;
        press_d    = '0;
        rep_cnt_d  = '0;
        click_d    = 1'b0;
        rep_pend_d = 1'b0;
      end
      // Long press: latch a repeat every interval once past the threshold.
      if (pressed_d && (press_d >= long_press_q) && (rep_cnt_d >= repeat_ticks_q)) begin
        rep_pend_d = 1'b1;
        rep_cnt_d  = '0;
      end
      // Debounced release: a short press becomes a click.
      if (!level_i && pressed_d) begin
        pressed_d  = 1'b0;
        click_d    = press_d < long_press_q;
        rep_pend_d = 1'b0;
        rep_cnt_d  = '0;
      end
    end

    // Report the state after this tick, then apply the acknowledges.
    out_click_d  = click_d;
    out_amount_d = rep_pend_d ? step_q : '0;
    out_held_d   = pressed_d;

    if (take_click_i)  click_d    = 1'b0;
    if (take_repeat_i) rep_pend_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_level_q <= 1'b0;
      stable_q     <= '0;
      pressed_q    <= 1'b0;
      press_q      <= '0;
      rep_cnt_q    <= '0;
      click_q      <= 1'b0;
      rep_pend_q   <= 1'b0;
    end else if (in_fire) begin
      prev_level_q <= prev_level_d;
      stable_q     <= stable_d;
      pressed_q    <= pressed_d;
      press_q      <= press_d;
      rep_cnt_q    <= rep_cnt_d;
      click_q      <= click_d;
      rep_pend_q   <= rep_pend_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_fire;
    end
  end

  // Payload of the result slot; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_click_q  <= out_click_d;
      out_amount_q <= out_amount_d;
      out_held_q   <= out_held_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign click_o         = out_click_q;
  assign repeat_amount_o = out_amount_q;
  assign held_o          = out_held_q;

endmodule

FILE: hdl/bdca_checker.sv
`timescale 1ns / 1ps

module bdca_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        click_o,
  input logic [7:0]  repeat_amount_o,
  input logic        held_o
);

  // An offered item stays offered until taken.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("input item withdrawn while waiting");

  // A waiting result stays until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Input is only held off by a stalled result.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // A click is a released state; it never shows while held.
  a_click_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(click_o && held_o))
    else $error("click reported while held");

  // Release clears any repeat, so a repeat amount implies held.
  a_repeat_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (repeat_amount_o != 8'd0) |-> held_o)
    else $error("repeat reported while released");

endmodule

bind button_debounce_click_autorepeat bdca_checker u_bdca_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .click_o         (click_o),
  .repeat_amount_o (repeat_amount_o),
  .held_o          (held_o)
);

FILE: tb/tb_button_debounce_click_autorepeat.sv
`timescale 1ns / 1ps

module tb_button_debounce_click_autorepeat;

  // One tick item and one result item, at the block's widths
  typedef struct packed {
    logic level;
    logic take_click;
    logic take_repeat;
  } tick_t;

  typedef struct packed {
    logic            click;
    bdca_pkg::step_t amount;
    logic            held;
  } result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Stimulus side of the block
  logic        in_valid         = 1'b0;
  logic        tick_level       = 1'b0;
  logic        tick_take_click  = 1'b0;
  logic        tick_take_repeat = 1'b0;
  logic        out_ready        = 1'b0;
  logic        cfg_valid        = 1'b0;
  logic [1:0]  cfg_idx          = bdca_pkg::CFG_DEBOUNCE;
  logic [15:0] cfg_wdata        = '0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic       click_o;
  logic [7:0] repeat_amount_o;
  logic       held_o;
  logic       cfg_ready_o;

  button_debounce_click_autorepeat i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .level_i         (tick_level),
    .take_click_i    (tick_take_click),
    .take_repeat_i   (tick_take_repeat),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .click_o         (click_o),
    .repeat_amount_o (repeat_amount_o),
    .held_o          (held_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_idx),
    .cfg_data_i      (cfg_wdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Pending tick items and the results they must produce, oldest first
  tick_t   tick_q[$];
  result_t expected_q[$];

  // Predictor copy of the registers, loaded with the reset defaults
  bdca_pkg::timer_t cfg_debounce   = bdca_pkg::DEBOUNCE_RST;
  bdca_pkg::timer_t cfg_long_press = bdca_pkg::LONG_PRESS_RST;
  bdca_pkg::timer_t cfg_repeat     = bdca_pkg::REPEAT_RST;
  bdca_pkg::step_t  cfg_step       = bdca_pkg::STEP_RST;

  // Predictor copy of the debounce and press state, all clear after reset
  logic              last_level     = 1'b0;
  bdca_pkg::stable_t stable_run     = '0;
  logic              is_pressed     = 1'b0;
  bdca_pkg::timer_t  press_age      = '0;
  bdca_pkg::timer_t  repeat_age     = '0;
  logic              click_latched  = 1'b0;
  logic              repeat_latched = 1'b0;

  int unsigned errors          = 0;
  int unsigned pushed          = 0;
  int unsigned results_seen    = 0;
  int unsigned clicks_latched  = 0;
  int unsigned repeats_latched = 0;
  int unsigned settings_used   = 0;
  int unsigned gap_left        = 0;
  int unsigned stall_left      = 0;
  bit          gappy           = 1'b1;

  tick_t   drv_tick;
  result_t mon_want;

  // Advance the debounce state by one tick and return the result it reports.
  // Timers run while pressed whether or not the level is stable; decisions
  // are only taken once the level has been stable past the debounce time.
  function automatic result_t debounce_tick(tick_t t);
    result_t r;
    if (is_pressed) begin
      if (press_age != bdca_pkg::TIMER_MAX) press_age++;
      if (repeat_age != bdca_pkg::TIMER_MAX) repeat_age++;
    end
    if (t.level != last_level) stable_run = '0;
    else if (stable_run != bdca_pkg::STABLE_MAX) stable_run++;

    if (stable_run > cfg_debounce) begin
      if (t.level && !is_pressed) begin
        is_pressed     = 1'b1;
        press_age      = '0;
        repeat_age     = '0;
        click_latched  = 1'b0;
        repeat_latched = 1'b0;
      end
      if (is_pressed && press_age >= cfg_long_press && repeat_age >= cfg_repeat) begin
        repeat_latched = 1'b1;
        repeat_age     = '0;
        repeats_latched++;
      end
      if (!t.level && is_pressed) begin
        is_pressed     = 1'b0;
        click_latched  = (press_age < cfg_long_press);
        repeat_latched = 1'b0;
        repeat_age     = '0;
        if (click_latched) clicks_latched++;
      end
    end
    last_level = t.level;

    r.click  = click_latched;
    r.amount = repeat_latched ? cfg_step : '0;
    r.held   = is_pressed;

    // Acknowledges clear the flags only after this result has shown them
    if (t.take_click) click_latched = 1'b0;
    if (t.take_repeat) repeat_latched = 1'b0;
    return r;
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gappy || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 40) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Driver: hold each item until it is taken, predict it on acceptance,
  // then idle for a random gap before offering the next one
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        expected_q.push_back(debounce_tick(drv_tick));
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (tick_q.size() != 0) begin
          drv_tick = tick_q.pop_front();
          tick_level       <= drv_tick.level;
          tick_take_click  <= drv_tick.take_click;
          tick_take_repeat <= drv_tick.take_repeat;
          in_valid         <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every accepted result with the oldest prediction,
  // then stall the output for a random gap
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          mon_want = expected_q.pop_front();
          if (click_o !== mon_want.click)
            report_mismatch($sformatf("result %0d click %b, expected %b",
                                      results_seen, click_o, mon_want.click));
          if (repeat_amount_o !== mon_want.amount)
            report_mismatch($sformatf("result %0d repeat_amount %0d, expected %0d",
                                      results_seen, repeat_amount_o, mon_want.amount));
          if (held_o !== mon_want.held)
            report_mismatch($sformatf("result %0d held %b, expected %b",
                                      results_seen, held_o, mon_want.held));
        end
        stall_left = pick_gap();
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Queue one tick with random acknowledges
  task automatic push_tick(input logic level);
    tick_t t;
    t.level       = level;
    t.take_click  = ($urandom_range(0, 7) == 0);
    t.take_repeat = ($urandom_range(0, 5) == 0);
    tick_q.push_back(t);
    pushed++;
  endtask

  // Queue n identical ticks with fixed acknowledges
  task automatic push_run(input logic level, input int unsigned n,
                          input logic tc, input logic tr);
    repeat (n) begin
      tick_q.push_back('{level, tc, tr});
      pushed++;
    end
  endtask

  // Write one register and update the predictor once the write is taken
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      bdca_pkg::CFG_DEBOUNCE:   cfg_debounce   = val;
      bdca_pkg::CFG_LONG_PRESS: cfg_long_press = val;
      bdca_pkg::CFG_REPEAT:     cfg_repeat     = val;
      bdca_pkg::CFG_STEP:       cfg_step       = val[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] deb, input logic [15:0] lp,
                            input logic [15:0] rep, input logic [15:0] stp);
    write_reg(bdca_pkg::CFG_DEBOUNCE, deb);
    write_reg(bdca_pkg::CFG_LONG_PRESS, lp);
    write_reg(bdca_pkg::CFG_REPEAT, rep);
    write_reg(bdca_pkg::CFG_STEP, stp);
    settings_used++;
  endtask

  // Wait until every queued item has gone in and every result has come out
  task automatic wait_idle();
    do @(posedge clk_i);
    while (tick_q.size() != 0 || in_valid || expected_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // One button gesture: mostly a clean press with bounce at both ends and
  // an occasional glitch mid-hold, sometimes pure noise
  task automatic push_burst();
    int unsigned hold;
    int unsigned cut;
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 10)) push_tick(1'($urandom_range(0, 1)));
    end else begin
      repeat ($urandom_range(0, 3)) push_tick(1'($urandom_range(0, 1)));
      hold = cfg_debounce + 1 +
             $urandom_range(0, 2 * cfg_long_press + 3 * cfg_repeat + 4);
      cut  = $urandom_range(0, hold);
      repeat (cut) push_tick(1'b1);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) push_tick(1'b0);
      repeat (hold - cut) push_tick(1'b1);
      repeat ($urandom_range(0, 3)) push_tick(1'($urandom_range(0, 1)));
      repeat (cfg_debounce + 1 + $urandom_range(0, 6)) push_tick(1'b0);
    end
  endtask

  initial begin
    int unsigned start;
    logic [15:0] stp;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: a few ticks that cannot get past the debounce yet
    settings_used++;
    push_run(1'b1, 2, 1'b1, 1'b1);
    push_run(1'b0, 1, 1'b0, 1'b0);
    wait_idle();

    // Zero long press, zero repeat interval and zero step: every press is
    // long, a repeat latches on each stable tick and reports amount 0
    set_config(16'd0, 16'd0, 16'd0, 16'd0);
    push_run(1'b1, 4, 1'b0, 1'b0);
    push_run(1'b1, 1, 1'b0, 1'b1);
    push_run(1'b0, 3, 1'b1, 1'b1);
    wait_idle();

    // Short press gives a click; long press with a glitch mid-hold repeats
    // at full step, and the timers keep running through the glitch
    set_config(16'd0, 16'd3, 16'd2, 16'd255);
    push_run(1'b1, 2, 1'b0, 1'b0);
    push_run(1'b0, 2, 1'b0, 1'b0);
    push_run(1'b0, 1, 1'b1, 1'b0);
    push_run(1'b1, 5, 1'b0, 1'b0);
    push_run(1'b0, 1, 1'b0, 1'b0);
    push_run(1'b1, 3, 1'b0, 1'b1);
    push_run(1'b0, 3, 1'b0, 1'b0);
    wait_idle();

    // Random gestures over a series of small settings
    for (int p = 0; p < 8; p++) begin
      gappy = ($urandom_range(0, 3) != 0);
      if (p == 0) stp = 16'hFFFF;
      else if (p == 1) stp = 16'h0000;
      else stp = 16'($urandom_range(0, 16'hFFFF));
      set_config(16'($urandom_range(0, 6)), 16'($urandom_range(0, 30)),
                 16'($urandom_range(0, 12)), stp);
      start = pushed;
      while (pushed - start < 120) push_burst();
      wait_idle();
    end

    // Maximum registers: a steady hold never gets past the debounce
    gappy = 1'b0;
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'($urandom_range(1, 255)));
    repeat (40) push_tick(1'b1);
    wait_idle();

    // Drop the debounce: the steady level presses at once, then release
    set_config(16'd0, 16'd1, 16'd1, 16'($urandom_range(0, 16'hFFFF)));
    repeat (3) push_tick(1'b1);
    repeat (4) push_tick(1'b0);
    wait_idle();

    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_q.size()));

    $display("Checked %0d tick results over %0d register settings.",
             results_seen, settings_used);
    $display("Predictor latched %0d clicks and %0d auto-repeats.",
             clicks_latched, repeats_latched);
    if (errors == 0) begin
      $display("tb_button_debounce_click_autorepeat: PASS");
    end else begin
      $display("tb_button_debounce_click_autorepeat: FAIL");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("tb_button_debounce_click_autorepeat: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
hdl/bdca_pkg.sv
hdl/button_debounce_click_autorepeat.sv
hdl/bdca_checker.sv
tb/tb_button_debounce_click_autorepeat.sv
